// File: rtl/ros_pkg.sv
// shared types, constants and codes of the operand stack unit
package ros_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
   localparam int TAG_W       = 4;
   localparam int VALUE_W     = 64;
   localparam int ENTRY_W     = TAG_W + VALUE_W;
   localparam int ACTION_W    = 5;
   localparam int DEPTH_W     = 7;

   localparam logic [TAG_W-1:0] TAG_INT = '0;

   typedef enum logic [ACTION_W-1:0] {
      A_PUSH   = 5'd0,
      A_DUP    = 5'd1,
      A_DROP   = 5'd2,
      A_SWAP   = 5'd3,
      A_OVER   = 5'd4,
      A_ROT    = 5'd5,
      A_UNROT  = 5'd6,
      A_DEPTH  = 5'd7,
      A_CLEAR  = 5'd8,
      A_DUP2   = 5'd9,
      A_DROP2  = 5'd10,
      A_DUPN   = 5'd11,
      A_DROPN  = 5'd12,
      A_PICK   = 5'd13,
      A_ROLL   = 5'd14,
      A_ROLLD  = 5'd15,
      A_UNPICK = 5'd16
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FEW  = 2'd1,
      ST_TYPE = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CNT,
      S_REP,
      S_EVAL,
      S_PK_RD,
      S_PK_WR,
      S_RT_LD,
      S_MV_RD,
      S_MV_WR,
      S_RT_PUT,
      S_FIN,
      S_TOP
   } state_type;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [TAG_W-1:0]          push_tag;
      logic signed [VALUE_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [DEPTH_W-1:0]        stack_depth;
      logic [TAG_W-1:0]          top_tag;
      logic signed [VALUE_W-1:0] top_value;
   } rsp_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
   } mem_req_type;

endpackage

// File: rtl/rpl_operand_stack_unit.sv
// top level of the operand stack unit: sequencer, stack ram and result register
//
//   port group   dir   contents
//   req_*        in    one stack command item (action, push_tag, push_value)
//   rsp_*        out   status, stack_depth, top_tag, top_value
//
// push, drop, drop2, clear and depth finish without a ram loop; the copy and rotate
// actions move words one at a time through the single read and write port of the ram.
// the next item can be taken in the same cycle as the result shows up.
// reset empties the stack at once; ram contents are left as they are.
// a result waits in its own register, so the next item is taken while it stalls;
// a second result waits in the sequencer until the register frees.
module rpl_operand_stack_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ros_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ros_pkg::rsp_type rsp_data
);

   ros_pkg::mem_req_type          mem_req;
   logic [ros_pkg::ENTRY_W-1:0]   mem_wdata, mem_rdata;
   logic                          done, slot_free;
   ros_pkg::rsp_type              res;
   logic                          rsp_valid_ff, rsp_valid_in;
   ros_pkg::rsp_type              rsp_ff, rsp_in;

   ros_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req_data),
      .done      (done),
      .res       (res),
      .slot_free (slot_free),
      .mem_req   (mem_req),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   ros_ram #(
      .WIDTH (ros_pkg::ENTRY_W),
      .DEPTH (ros_pkg::STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rdata),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_wdata)
   );

   // result register
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = done ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a result is only handed over when the register can take it
   a_done_free: assert property (@(posedge clock) disable iff (reset)
      done |-> slot_free)
      else $error("result produced while result register is busy");

   // one item at a time through the sequencer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item still in work");

   // the sequencer never reads and writes the ram in the same cycle
   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("ram read and write issued together");

endmodule

// File: rtl/ros_ram.sv
// generic single-port-write, single-port-read ram with registered read
module ros_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: rtl/ros_ctrl.sv
// command sequencer: checks, count pop, copy and rotate loops over the stack ram
module ros_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  ros_pkg::req_type             req,
   output logic                         done,
   output ros_pkg::rsp_type             res,
   input  logic                         slot_free,
   output ros_pkg::mem_req_type         mem_req,
   output logic [ros_pkg::ENTRY_W-1:0]  mem_wdata,
   input  logic [ros_pkg::ENTRY_W-1:0]  mem_rdata
);

   ros_pkg::state_type              state_ff, state_in;
   ros_pkg::status_type             st_ff, st_in;
   logic [ros_pkg::ACTION_W-1:0]    act_ff, act_in;
   logic [ros_pkg::PTR_W-1:0]       sp_ff, sp_in;
   logic [ros_pkg::PTR_W-1:0]       k_ff, k_in;
   logic [ros_pkg::PTR_W-1:0]       cnt_ff, cnt_in;
   logic [ros_pkg::ADDR_W-1:0]      cur_ff, cur_in;
   logic [ros_pkg::ENTRY_W-1:0]     t_ff, t_in;
   logic                            big_ff, big_in;
   logic                            up_ff, up_in;

   logic [ros_pkg::PTR_W-1:0]       sp_m1, sp_m2, sp_m3, sp_p1, sp_mk;
   logic [ros_pkg::PTR_W:0]         sum2, sumk;
   logic                            full, room2, roomk, cnt_ok, zero_ok;
   logic [ros_pkg::TAG_W-1:0]       rd_tag;

   // address and limit helpers
   assign sp_m1  = sp_ff - ros_pkg::PTR_W'(1);
   assign sp_m2  = sp_ff - ros_pkg::PTR_W'(2);
   assign sp_m3  = sp_ff - ros_pkg::PTR_W'(3);
   assign sp_p1  = sp_ff + ros_pkg::PTR_W'(1);
   assign sp_mk  = sp_ff - k_ff;
   assign sum2   = {1'b0, sp_ff} + (ros_pkg::PTR_W+1)'(2);
   assign sumk   = {1'b0, sp_ff} + {1'b0, k_ff};
   assign full   = sp_ff >= ros_pkg::PTR_W'(ros_pkg::STACK_DEPTH);
   assign room2  = sum2 <= (ros_pkg::PTR_W+1)'(ros_pkg::STACK_DEPTH);
   assign roomk  = sumk <= (ros_pkg::PTR_W+1)'(ros_pkg::STACK_DEPTH);
   assign zero_ok = (act_ff == ros_pkg::A_DUPN) || (act_ff == ros_pkg::A_DROPN);
   assign cnt_ok = !big_ff && (k_ff <= sp_ff) && ((k_ff != '0) || zero_ok);
   assign rd_tag = mem_rdata[ros_pkg::ENTRY_W-1 -: ros_pkg::TAG_W];

   assign req_ready = (state_ff == ros_pkg::S_IDLE);

   // next state and command status
   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      unique case (state_ff)
         ros_pkg::S_IDLE: begin
            if (req_valid) begin
               st_in    = ros_pkg::ST_OK;
               state_in = ros_pkg::S_FIN;
               case (req.action) inside
                  ros_pkg::A_PUSH, ros_pkg::A_DEPTH: begin
                     if (full) st_in = ros_pkg::ST_FULL;
                  end
                  ros_pkg::A_DUP: begin
                     if (sp_ff == '0) st_in = ros_pkg::ST_FEW;
                     else if (full) st_in = ros_pkg::ST_FULL;
                     else state_in = ros_pkg::S_PK_RD;
                  end
                  ros_pkg::A_OVER: begin
                     if (sp_ff < ros_pkg::PTR_W'(2)) st_in = ros_pkg::ST_FEW;
                     else if (full) st_in = ros_pkg::ST_FULL;
                     else state_in = ros_pkg::S_PK_RD;
                  end
                  ros_pkg::A_DUP2: begin
                     if (sp_ff < ros_pkg::PTR_W'(2)) st_in = ros_pkg::ST_FEW;
                     else if (!room2) st_in = ros_pkg::ST_FULL;
                     else state_in = ros_pkg::S_PK_RD;
                  end
                  ros_pkg::A_DROP: begin
                     if (sp_ff == '0) st_in = ros_pkg::ST_FEW;
                  end
                  ros_pkg::A_DROP2: begin
                     if (sp_ff < ros_pkg::PTR_W'(2)) st_in = ros_pkg::ST_FEW;
                  end
                  ros_pkg::A_SWAP: begin
                     if (sp_ff < ros_pkg::PTR_W'(2)) st_in = ros_pkg::ST_FEW;
                     else state_in = ros_pkg::S_RT_LD;
                  end
                  ros_pkg::A_ROT, ros_pkg::A_UNROT: begin
                     if (sp_ff < ros_pkg::PTR_W'(3)) st_in = ros_pkg::ST_FEW;
                     else state_in = ros_pkg::S_RT_LD;
                  end
                  ros_pkg::A_DUPN, ros_pkg::A_DROPN, ros_pkg::A_PICK,
                  ros_pkg::A_ROLL, ros_pkg::A_ROLLD: begin
                     if (sp_ff == '0) st_in = ros_pkg::ST_FEW;
                     else state_in = ros_pkg::S_CNT;
                  end
                  ros_pkg::A_UNPICK: begin
                     if (sp_ff < ros_pkg::PTR_W'(2)) st_in = ros_pkg::ST_FEW;
                     else state_in = ros_pkg::S_CNT;
                  end
                  default: ;
               endcase
            end
         end
         ros_pkg::S_CNT: begin
            if (rd_tag != ros_pkg::TAG_INT) begin
               st_in    = ros_pkg::ST_TYPE;
               state_in = ros_pkg::S_FIN;
            end else if (act_ff == ros_pkg::A_UNPICK) begin
               state_in = ros_pkg::S_REP;
            end else begin
               state_in = ros_pkg::S_EVAL;
            end
         end
         ros_pkg::S_REP: state_in = ros_pkg::S_EVAL;
         ros_pkg::S_EVAL: begin
            state_in = ros_pkg::S_FIN;
            if (!cnt_ok) begin
               st_in = ros_pkg::ST_FEW;
            end else begin
               case (act_ff)
                  ros_pkg::A_DUPN: begin
                     if (!roomk) st_in = ros_pkg::ST_FULL;
                     else if (k_ff != '0) state_in = ros_pkg::S_PK_RD;
                  end
                  ros_pkg::A_PICK: state_in = ros_pkg::S_PK_RD;
                  ros_pkg::A_ROLL, ros_pkg::A_ROLLD: state_in = ros_pkg::S_RT_LD;
                  default: ;
               endcase
            end
         end
         ros_pkg::S_PK_RD: state_in = ros_pkg::S_PK_WR;
         ros_pkg::S_PK_WR: begin
            state_in = (cnt_ff == ros_pkg::PTR_W'(1)) ? ros_pkg::S_FIN : ros_pkg::S_PK_RD;
         end
         ros_pkg::S_RT_LD: begin
            state_in = (cnt_ff == '0) ? ros_pkg::S_RT_PUT : ros_pkg::S_MV_RD;
         end
         ros_pkg::S_MV_RD: state_in = ros_pkg::S_MV_WR;
         ros_pkg::S_MV_WR: begin
            state_in = (cnt_ff == ros_pkg::PTR_W'(1)) ? ros_pkg::S_RT_PUT
                                                        : ros_pkg::S_MV_RD;
         end
         ros_pkg::S_RT_PUT: state_in = ros_pkg::S_FIN;
         ros_pkg::S_FIN: state_in = ros_pkg::S_TOP;
         ros_pkg::S_TOP: begin
            if (slot_free) state_in = ros_pkg::S_IDLE;
         end
         default: state_in = ros_pkg::S_IDLE;
      endcase
   end

   // datapath, ram requests and result
   always_comb begin
      act_in    = act_ff;
      sp_in     = sp_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      cur_in    = cur_ff;
      t_in      = t_ff;
      big_in    = big_ff;
      up_in     = up_ff;
      mem_req   = '0;
      mem_wdata = mem_rdata;
      done      = 1'b0;
      unique case (state_ff)
         ros_pkg::S_IDLE: begin
            act_in = req.action;
            case (req.action) inside
               ros_pkg::A_PUSH: begin
                  mem_wdata = {req.push_tag, req.push_value};
                  if (st_in == ros_pkg::ST_OK) begin
                     mem_req.wr_en   = req_valid;
                     mem_req.wr_addr = sp_ff[ros_pkg::ADDR_W-1:0];
                     if (req_valid) sp_in = sp_p1;
                  end
               end
               ros_pkg::A_DEPTH: begin
                  mem_wdata = {ros_pkg::TAG_INT, ros_pkg::VALUE_W'(sp_ff)};
                  if (st_in == ros_pkg::ST_OK) begin
                     mem_req.wr_en   = req_valid;
                     mem_req.wr_addr = sp_ff[ros_pkg::ADDR_W-1:0];
                     if (req_valid) sp_in = sp_p1;
                  end
               end
               ros_pkg::A_DROP: begin
                  if (req_valid && st_in == ros_pkg::ST_OK) sp_in = sp_m1;
               end
               ros_pkg::A_DROP2: begin
                  if (req_valid && st_in == ros_pkg::ST_OK) sp_in = sp_m2;
               end
               ros_pkg::A_CLEAR: begin
                  if (req_valid) sp_in = '0;
               end
               ros_pkg::A_DUP: begin
                  k_in   = ros_pkg::PTR_W'(1);
                  cnt_in = ros_pkg::PTR_W'(1);
               end
               ros_pkg::A_OVER: begin
                  k_in   = ros_pkg::PTR_W'(2);
                  cnt_in = ros_pkg::PTR_W'(1);
               end
               ros_pkg::A_DUP2: begin
                  k_in   = ros_pkg::PTR_W'(2);
                  cnt_in = ros_pkg::PTR_W'(2);
               end
               ros_pkg::A_SWAP: begin
                  up_in           = 1'b1;
                  cur_in          = sp_m2[ros_pkg::ADDR_W-1:0];
                  cnt_in          = ros_pkg::PTR_W'(1);
                  mem_req.rd_en   = (state_in == ros_pkg::S_RT_LD);
                  mem_req.rd_addr = sp_m2[ros_pkg::ADDR_W-1:0];
               end
               ros_pkg::A_ROT: begin
                  up_in           = 1'b1;
                  cur_in          = sp_m3[ros_pkg::ADDR_W-1:0];
                  cnt_in          = ros_pkg::PTR_W'(2);
                  mem_req.rd_en   = (state_in == ros_pkg::S_RT_LD);
                  mem_req.rd_addr = sp_m3[ros_pkg::ADDR_W-1:0];
               end
               ros_pkg::A_UNROT: begin
                  up_in           = 1'b0;
                  cur_in          = sp_m1[ros_pkg::ADDR_W-1:0];
                  cnt_in          = ros_pkg::PTR_W'(2);
                  mem_req.rd_en   = (state_in == ros_pkg::S_RT_LD);
                  mem_req.rd_addr = sp_m1[ros_pkg::ADDR_W-1:0];
               end
               ros_pkg::A_DUPN, ros_pkg::A_DROPN, ros_pkg::A_PICK,
               ros_pkg::A_ROLL, ros_pkg::A_ROLLD, ros_pkg::A_UNPICK: begin
                  mem_req.rd_en   = (state_in == ros_pkg::S_CNT);
                  mem_req.rd_addr = sp_m1[ros_pkg::ADDR_W-1:0];
               end
               default: ;
            endcase
         end
         // count word: pop it, keep its low bits and an out-of-range flag
         ros_pkg::S_CNT: begin
            sp_in  = sp_m1;
            k_in   = mem_rdata[ros_pkg::PTR_W-1:0];
            big_in = |mem_rdata[ros_pkg::VALUE_W-1:ros_pkg::PTR_W];
            mem_req.rd_en   = (state_in == ros_pkg::S_REP);
            mem_req.rd_addr = sp_m2[ros_pkg::ADDR_W-1:0];
         end
         // replacement word of unpick
         ros_pkg::S_REP: begin
            t_in  = mem_rdata;
            sp_in = sp_m1;
         end
         ros_pkg::S_EVAL: begin
            mem_wdata = t_ff;
            case (act_ff)
               ros_pkg::A_DUPN: cnt_in = k_ff;
               ros_pkg::A_PICK: cnt_in = ros_pkg::PTR_W'(1);
               ros_pkg::A_DROPN: begin
                  if (cnt_ok) sp_in = sp_mk;
               end
               ros_pkg::A_ROLL: begin
                  up_in           = 1'b1;
                  cur_in          = sp_mk[ros_pkg::ADDR_W-1:0];
                  cnt_in          = k_ff - ros_pkg::PTR_W'(1);
                  mem_req.rd_en   = cnt_ok;
                  mem_req.rd_addr = sp_mk[ros_pkg::ADDR_W-1:0];
               end
               ros_pkg::A_ROLLD: begin
                  up_in           = 1'b0;
                  cur_in          = sp_m1[ros_pkg::ADDR_W-1:0];
                  cnt_in          = k_ff - ros_pkg::PTR_W'(1);
                  mem_req.rd_en   = cnt_ok;
                  mem_req.rd_addr = sp_m1[ros_pkg::ADDR_W-1:0];
               end
               ros_pkg::A_UNPICK: begin
                  mem_req.wr_en   = cnt_ok;
                  mem_req.wr_addr = sp_mk[ros_pkg::ADDR_W-1:0];
               end
               default: ;
            endcase
         end
         // copy level k onto the top, cnt times
         ros_pkg::S_PK_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = sp_mk[ros_pkg::ADDR_W-1:0];
         end
         ros_pkg::S_PK_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = sp_ff[ros_pkg::ADDR_W-1:0];
            sp_in           = sp_p1;
            cnt_in          = cnt_ff - ros_pkg::PTR_W'(1);
         end
         // rotate: hold the end word, shift the rest one level
         ros_pkg::S_RT_LD: t_in = mem_rdata;
         ros_pkg::S_MV_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = up_ff ? cur_ff + ros_pkg::ADDR_W'(1)
                                    : cur_ff - ros_pkg::ADDR_W'(1);
         end
         ros_pkg::S_MV_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
            cur_in          = up_ff ? cur_ff + ros_pkg::ADDR_W'(1)
                                    : cur_ff - ros_pkg::ADDR_W'(1);
            cnt_in          = cnt_ff - ros_pkg::PTR_W'(1);
         end
         ros_pkg::S_RT_PUT: begin
            mem_wdata       = t_ff;
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
         end
         // fetch level one for the result
         ros_pkg::S_FIN: begin
            mem_req.rd_en   = (sp_ff != '0);
            mem_req.rd_addr = sp_m1[ros_pkg::ADDR_W-1:0];
         end
         ros_pkg::S_TOP: done = slot_free;
         default: ;
      endcase
   end

   // result fields
   always_comb begin
      res.status      = st_ff;
      res.stack_depth = ros_pkg::DEPTH_W'(sp_ff);
      if (sp_ff != '0) begin
         res.top_tag   = rd_tag;
         res.top_value = mem_rdata[ros_pkg::VALUE_W-1:0];
      end else begin
         res.top_tag   = '0;
         res.top_value = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ros_pkg::S_IDLE;
         sp_ff    <= '0;
         st_ff    <= ros_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         st_ff    <= st_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff <= act_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      cur_ff <= cur_in;
      t_ff   <= t_in;
      big_ff <= big_in;
      up_ff  <= up_in;
   end

endmodule

// File: tb/rpl_operand_stack_unit_chk.sv
// checker for the operand stack unit: command predictor and result comparison
module rpl_operand_stack_unit_chk (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ros_pkg::req_type req,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ros_pkg::rsp_type rsp,
   output int               mismatches,
   output int               pending,
   output int               checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // predicted stack contents
   logic [ros_pkg::TAG_W-1:0]   tag_mem [ros_pkg::STACK_DEPTH];
   logic [ros_pkg::VALUE_W-1:0] word_mem [ros_pkg::STACK_DEPTH];
   int                          depth_now;
   ros_pkg::rsp_type            expected_rsps [$];

   // copy one stack entry
   function automatic void move_entry(int dst, int src);
      tag_mem[dst]  = tag_mem[src];
      word_mem[dst] = word_mem[src];
   endfunction

   // carry out one command on the predicted stack, return its status
   function automatic ros_pkg::status_type run_command(ros_pkg::req_type r);
      int                          d;
      int                          k;
      longint signed               n;
      logic [ros_pkg::TAG_W-1:0]   held_tag;
      logic [ros_pkg::VALUE_W-1:0] held_word;
      ros_pkg::action_type         act;
      d   = depth_now;
      act = ros_pkg::action_type'(r.action);
      case (act)
         ros_pkg::A_PUSH: begin
            if (d >= ros_pkg::STACK_DEPTH) return ros_pkg::ST_FULL;
            tag_mem[d]  = r.push_tag;
            word_mem[d] = r.push_value;
            depth_now   = d + 1;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_DUP: begin
            if (d < 1) return ros_pkg::ST_FEW;
            if (d >= ros_pkg::STACK_DEPTH) return ros_pkg::ST_FULL;
            move_entry(d, d - 1);
            depth_now = d + 1;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_DROP: begin
            if (d < 1) return ros_pkg::ST_FEW;
            depth_now = d - 1;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_SWAP: begin
            if (d < 2) return ros_pkg::ST_FEW;
            held_tag = tag_mem[d-1]; held_word = word_mem[d-1];
            move_entry(d - 1, d - 2);
            tag_mem[d-2] = held_tag; word_mem[d-2] = held_word;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_OVER: begin
            if (d < 2) return ros_pkg::ST_FEW;
            if (d >= ros_pkg::STACK_DEPTH) return ros_pkg::ST_FULL;
            move_entry(d, d - 2);
            depth_now = d + 1;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_ROT: begin
            if (d < 3) return ros_pkg::ST_FEW;
            held_tag = tag_mem[d-3]; held_word = word_mem[d-3];
            move_entry(d - 3, d - 2);
            move_entry(d - 2, d - 1);
            tag_mem[d-1] = held_tag; word_mem[d-1] = held_word;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_UNROT: begin
            if (d < 3) return ros_pkg::ST_FEW;
            held_tag = tag_mem[d-1]; held_word = word_mem[d-1];
            move_entry(d - 1, d - 2);
            move_entry(d - 2, d - 3);
            tag_mem[d-3] = held_tag; word_mem[d-3] = held_word;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_DEPTH: begin
            if (d >= ros_pkg::STACK_DEPTH) return ros_pkg::ST_FULL;
            tag_mem[d]  = ros_pkg::TAG_INT;
            word_mem[d] = ros_pkg::VALUE_W'(d);
            depth_now   = d + 1;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_CLEAR: begin
            depth_now = 0;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_DUP2: begin
            if (d < 2) return ros_pkg::ST_FEW;
            if (d + 2 > ros_pkg::STACK_DEPTH) return ros_pkg::ST_FULL;
            move_entry(d, d - 2);
            move_entry(d + 1, d - 1);
            depth_now = d + 2;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_DROP2: begin
            if (d < 2) return ros_pkg::ST_FEW;
            depth_now = d - 2;
            return ros_pkg::ST_OK;
         end
         ros_pkg::A_DUPN, ros_pkg::A_DROPN, ros_pkg::A_PICK, ros_pkg::A_ROLL,
         ros_pkg::A_ROLLD, ros_pkg::A_UNPICK: ;
         default: return ros_pkg::ST_OK;
      endcase

      // counted commands: pop the count word first
      if (d < ((act == ros_pkg::A_UNPICK) ? 2 : 1)) return ros_pkg::ST_FEW;
      depth_now = depth_now - 1;
      if (tag_mem[depth_now] != ros_pkg::TAG_INT) return ros_pkg::ST_TYPE;
      n = $signed(word_mem[depth_now]);
      held_tag  = '0;
      held_word = '0;
      if (act == ros_pkg::A_UNPICK) begin
         depth_now = depth_now - 1;
         held_tag  = tag_mem[depth_now];
         held_word = word_mem[depth_now];
      end
      d = depth_now;
      if (n < ((act == ros_pkg::A_DUPN || act == ros_pkg::A_DROPN) ? 0 : 1) || n > d)
         return ros_pkg::ST_FEW;
      k = int'(n);
      case (act)
         ros_pkg::A_DUPN: begin
            if (d + k > ros_pkg::STACK_DEPTH) return ros_pkg::ST_FULL;
            for (int i = 0; i < k; i++) move_entry(d + i, d + i - k);
            depth_now = d + k;
         end
         ros_pkg::A_DROPN: depth_now = d - k;
         ros_pkg::A_PICK: begin
            move_entry(d, d - k);
            depth_now = d + 1;
         end
         ros_pkg::A_ROLL: begin
            held_tag = tag_mem[d-k]; held_word = word_mem[d-k];
            for (int i = d - k; i + 1 < d; i++) move_entry(i, i + 1);
            tag_mem[d-1] = held_tag; word_mem[d-1] = held_word;
         end
         ros_pkg::A_ROLLD: begin
            held_tag = tag_mem[d-1]; held_word = word_mem[d-1];
            for (int i = d - 1; i > d - k; i--) move_entry(i, i - 1);
            tag_mem[d-k] = held_tag; word_mem[d-k] = held_word;
         end
         default: begin
            tag_mem[d-k] = held_tag; word_mem[d-k] = held_word;
         end
      endcase
      return ros_pkg::ST_OK;
   endfunction

   // full result of one command
   function automatic ros_pkg::rsp_type predict_result(ros_pkg::req_type r);
      ros_pkg::rsp_type e;
      e.status      = run_command(r);
      e.stack_depth = ros_pkg::DEPTH_W'(depth_now);
      e.top_tag     = (depth_now > 0) ? tag_mem[depth_now-1] : '0;
      e.top_value   = (depth_now > 0) ? word_mem[depth_now-1] : '0;
      return e;
   endfunction

   assign pending = expected_rsps.size();

   // watch both channels at the rising edge
   always @(posedge clock) begin
      ros_pkg::rsp_type e;
      if (reset) begin
         depth_now <= 0;
         mismatches <= 0;
         checked <= 0;
         expected_rsps.delete();
      end else begin
         if (req_valid && req_ready)
            expected_rsps.insert(expected_rsps.size(), predict_result(req));
         if (rsp_valid && rsp_ready) begin
            checked <= checked + 1;
            if (expected_rsps.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result with no command waiting: %p", $realtime, rsp);
               mismatches <= mismatches + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp.status !== e.status || rsp.stack_depth !== e.stack_depth ||
                   rsp.top_tag !== e.top_tag || rsp.top_value !== e.top_value) begin
                  if (mismatches < 10)
                     $display("%0t: result differs\n  expected %p\n  actual   %p",
                              $realtime, e, rsp);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end
endmodule

// File: tb/rpl_operand_stack_unit_tb.sv
// top of the operand stack unit testbench: clock, reset, command stimulus and verdict
module rpl_operand_stack_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 320;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   ros_pkg::req_type req;
   logic             rsp_valid;
   logic             rsp_ready;
   ros_pkg::rsp_type rsp;
   int               mismatches;
   int               pending;
   int               checked;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               sent;
   int               quiet_cycles;

   rpl_operand_stack_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp)
   );

   rpl_operand_stack_unit_chk i_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
      .mismatches(mismatches), .pending(pending), .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side stalls at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (!reset && quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending);
         $display("Mismatches found");
         $finish;
      end
   end

   // present one command and hold it until taken
   task automatic send_cmd(ros_pkg::action_type act, logic [ros_pkg::TAG_W-1:0] tag,
                           logic [ros_pkg::VALUE_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req.action     <= act;
      req.push_tag   <= tag;
      req.push_value <= val;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic push_int(longint val);
      send_cmd(ros_pkg::A_PUSH, ros_pkg::TAG_INT, val);
   endtask

   function automatic logic [ros_pkg::VALUE_W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 64'h7fff_ffff_ffff_ffff;
         1: return 64'h8000_0000_0000_0000;
         2: return 64'(longint'($urandom_range(0, 9)) - 4);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // a count for counted commands: mostly in range, sometimes not
   function automatic longint rand_count();
      case ($urandom_range(0, 19))
         0: return -longint'($urandom_range(1, 3));
         1: return $urandom_range(60, 80);
         2: return {$urandom, $urandom};
         default: return $urandom_range(0, 8);
      endcase
   endfunction

   // one random command, or a count and a counted command, at times with a dropn between
   task automatic random_cmd();
      int pick;
      ros_pkg::action_type act;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         send_cmd(ros_pkg::A_PUSH,
                  ($urandom_range(0, 3) == 0) ? 4'($urandom) : ros_pkg::TAG_INT,
                  rand_word());
      end else if (pick < 55) begin
         act = ros_pkg::action_type'($urandom_range(ros_pkg::A_DUPN, ros_pkg::A_UNPICK));
         if ($urandom_range(0, 19) == 0)
            send_cmd(ros_pkg::A_PUSH, 4'($urandom_range(1, 15)), rand_word());
         else push_int(rand_count());
         if (act == ros_pkg::A_DUPN && $urandom_range(0, 1))
            send_cmd(ros_pkg::A_DROPN, ros_pkg::TAG_INT, 0);
         send_cmd(act, 4'($urandom), {$urandom, $urandom});
      end else if (pick < 57) begin
         send_cmd(ros_pkg::A_CLEAR, 4'($urandom), rand_word());
      end else begin
         act = ros_pkg::action_type'($urandom_range(ros_pkg::A_DUP, ros_pkg::A_UNPICK));
         send_cmd(act, 4'($urandom), {$urandom, $urandom});
      end
   endtask

   initial begin
      req_valid     = 1'b0;
      req           = '0;
      rsp_ready     = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      sent          = 0;
      quiet_cycles  = 0;
      reset         = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed commands: empty stack, every action, count corner cases
      send_cmd(ros_pkg::A_DROP, 4'hf, '1);
      send_cmd(ros_pkg::A_SWAP, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_PUSH, 4'hf, 64'h7fff_ffff_ffff_ffff);
      send_cmd(ros_pkg::A_PUSH, 4'h5, 64'h8000_0000_0000_0000);
      push_int(3);
      send_cmd(ros_pkg::A_DUP, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_SWAP, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_OVER, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_ROT, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_UNROT, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_DEPTH, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_DUP2, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_DROP2, ros_pkg::TAG_INT, '0);
      push_int(2); send_cmd(ros_pkg::A_DUPN, ros_pkg::TAG_INT, '0);
      push_int(3); send_cmd(ros_pkg::A_PICK, ros_pkg::TAG_INT, '0);
      push_int(4); send_cmd(ros_pkg::A_ROLL, ros_pkg::TAG_INT, '0);
      push_int(4); send_cmd(ros_pkg::A_ROLLD, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_PUSH, 4'ha, 64'h1234);
      push_int(2); send_cmd(ros_pkg::A_UNPICK, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_PUSH, 4'h1, 1); send_cmd(ros_pkg::A_DROPN, ros_pkg::TAG_INT, '0);
      push_int(-1); send_cmd(ros_pkg::A_PICK, ros_pkg::TAG_INT, '0);
      push_int(100); send_cmd(ros_pkg::A_ROLL, ros_pkg::TAG_INT, '0);
      push_int(0); send_cmd(ros_pkg::A_DUPN, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_CLEAR, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_UNPICK, ros_pkg::TAG_INT, '0);

      // fill the stack and hit every refused push
      for (int i = 0; i < ros_pkg::STACK_DEPTH; i++)
         send_cmd(ros_pkg::A_PUSH, 4'($urandom), rand_word());
      send_cmd(ros_pkg::A_PUSH, ros_pkg::TAG_INT, 1);
      send_cmd(ros_pkg::A_DUP, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_OVER, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_DEPTH, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_DROP, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_DUP2, ros_pkg::TAG_INT, '0);
      push_int(2); send_cmd(ros_pkg::A_DUPN, ros_pkg::TAG_INT, '0);
      push_int(63); send_cmd(ros_pkg::A_ROLL, ros_pkg::TAG_INT, '0);
      push_int(62); send_cmd(ros_pkg::A_ROLLD, ros_pkg::TAG_INT, '0);
      push_int(63); send_cmd(ros_pkg::A_PICK, ros_pkg::TAG_INT, '0);
      send_cmd(ros_pkg::A_CLEAR, ros_pkg::TAG_INT, '0);

      // random phases with different idling on each side
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 53; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 53; end
            default: begin send_idle_pct = 31; recv_idle_pct = 31; end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) random_cmd();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (200) @(posedge clock);

      $display("ran %0d stack commands over four idling phases, %0d results compared",
               sent, checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d results differed", mismatches);
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/ros_pkg.sv
rtl/ros_ram.sv
rtl/ros_ctrl.sv
rtl/rpl_operand_stack_unit.sv
tb/rpl_operand_stack_unit_chk.sv
tb/rpl_operand_stack_unit_tb.sv
